FILE: design/latin_hypercube_builder_maximin_assert.svh
// Assertion macros for the Latin hypercube builder.
// Used by the top level; expects signals named clk and rst where it is expanded.
`ifndef LATIN_HYPERCUBE_BUILDER_MAXIMIN_ASSERT_SVH
`define LATIN_HYPERCUBE_BUILDER_MAXIMIN_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LHBM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LHBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/lhbm_pkg.sv
// Shared types and constants for the Latin hypercube builder.
// No dependencies; lhbm_lane, lhbm_merge and the top level import this package.
package lhbm_pkg;

  localparam int DIMENSIONS_DEF = 4;
  localparam int POINTS_DEF     = 16;

  localparam int PICK_BITS   = 4;
  localparam int PICK_WIDTH  = 16;
  localparam int POINT_WIDTH = 16;
  localparam int MIN_W       = 14;
  localparam int COUNT_OUT_W = 5;

  localparam logic [MIN_W-1:0] START_MIN = MIN_W'(10000);

  localparam logic KIND_PLACE = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [PICK_WIDTH-1:0] picks;
  } lhbm_req_t;

  typedef struct packed {
    logic [POINT_WIDTH-1:0] point;
    logic [MIN_W-1:0]       min_distance;
    logic [COUNT_OUT_W-1:0] placed_count;
    logic                   complete;
    logic                   error;
  } lhbm_rsp_t;

  // Controls from the sequencer to every dimension lane.
  typedef struct packed {
    logic clear;
    logic rd_pick;
    logic rd_last;
    logic take;
    logic put;
    logic sq_en;
  } pool_op_t;

  // Controls from the sequencer to the distance merge stage.
  typedef struct packed {
    logic clear;
    logic sum_en;
    logic cmp_en;
  } merge_op_t;

endpackage

FILE: design/lhbm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lhbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/lhbm_lane.sv
// One dimension lane: its pool of unused levels, the taken coordinate and
// the squared coordinate difference against a stored point.
// Depends on lhbm_pkg and lhbm_ram.
module lhbm_lane #(
  parameter int POINTS = lhbm_pkg::POINTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lhbm_pkg::pool_op_t          op,
  input  logic [$clog2(POINTS)-1:0]   pick_idx,
  input  logic [$clog2(POINTS)-1:0]   last_idx,
  input  logic [$clog2(POINTS)-1:0]   stored,
  output logic [$clog2(POINTS)-1:0]   coord,
  output logic [2*$clog2(POINTS)-1:0] sq
);
  import lhbm_pkg::*;

  localparam int LW  = $clog2(POINTS);
  localparam int SQW = 2 * LW;

  logic [POINTS-1:0] valid;
  logic [LW-1:0]     rd_addr;
  logic              rd_en;
  logic [LW-1:0]     ram_q;
  logic [LW-1:0]     addr_q;
  logic              hit_q;
  logic [LW-1:0]     level;
  logic [LW-1:0]     diff;

  assign rd_en   = op.rd_pick | op.rd_last;
  assign rd_addr = op.rd_last ? last_idx : pick_idx;

  // An entry never written since the last clear still holds its own index.
  assign level = hit_q ? ram_q : addr_q;
  assign diff  = (stored > coord) ? (stored - coord) : (coord - stored);

  lhbm_ram #(
    .WIDTH (LW),
    .DEPTH (POINTS)
  ) u_pool (
    .clk     (clk),
    .wr_en   (op.put),
    .wr_addr (pick_idx),
    .wr_data (level),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (op.clear) begin
      valid <= '0;
    end else if (op.put) begin
      valid[pick_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      addr_q <= rd_addr;
      hit_q  <= valid[rd_addr];
    end
    if (op.take) begin
      coord <= level;
    end
    if (op.sq_en) begin
      sq <= SQW'(diff) * SQW'(diff);
    end
  end

endmodule

FILE: design/lhbm_merge.sv
// Merge stage: sums the lanes' squared differences and keeps the running
// minimum squared distance. Depends on lhbm_pkg.
module lhbm_merge #(
  parameter int DIMENSIONS = lhbm_pkg::DIMENSIONS_DEF,
  parameter int POINTS     = lhbm_pkg::POINTS_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  lhbm_pkg::merge_op_t                                 op,
  input  logic [DIMENSIONS-1:0][2*$clog2(POINTS)-1:0]         sq,
  output logic [lhbm_pkg::MIN_W-1:0]                          best_min
);
  import lhbm_pkg::*;

  localparam int SQW = 2 * $clog2(POINTS);
  localparam int DW  = SQW + $clog2(DIMENSIONS);
  localparam int MW  = (DW > MIN_W) ? DW : MIN_W;

  logic [DW-1:0] sum;
  logic [DW-1:0] sum_q;

  always_comb begin
    sum = '0;
    for (int d = 0; d < DIMENSIONS; d++) begin
      sum = sum + DW'(sq[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (op.sum_en) begin
      sum_q <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_min <= START_MIN;
    end else if (op.clear) begin
      best_min <= START_MIN;
    end else if (op.cmp_en && (MW'(sum_q) < MW'(best_min))) begin
      best_min <= MIN_W'(sum_q);
    end
  end

endmodule

FILE: design/latin_hypercube_builder_maximin.sv
// Latin hypercube builder with a running maximin score. Each request either
// clears the block or places one point, taking one level per dimension from
// that dimension's pool of unused levels, and returns one result. A clear or
// a rejected place request goes from the check state straight to the result
// state. An accepted place request passes the check, take and put states, which
// read and update the pools, then reads the earlier points one per cycle from
// the point memory, lets the lanes and merge stage drain, and issues the result
// once the pipeline is empty. A stalled result holds the block until it is
// taken. One request is in work at a time. The level pools come out of reset
// and clear ready to use, with no clearing pass.
// Depends on lhbm_pkg, lhbm_ram, lhbm_lane, lhbm_merge and the assertion header.
`include "latin_hypercube_builder_maximin_assert.svh"

module latin_hypercube_builder_maximin #(
  parameter int DIMENSIONS = lhbm_pkg::DIMENSIONS_DEF,
  parameter int POINTS     = lhbm_pkg::POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  lhbm_pkg::lhbm_req_t req_data,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output lhbm_pkg::lhbm_rsp_t rsp_data
);
  import lhbm_pkg::*;

  localparam int LW         = $clog2(POINTS);
  localparam int CW         = $clog2(POINTS + 1);
  localparam int SQW        = 2 * LW;
  localparam int SW         = DIMENSIONS * LW;
  localparam int FIELD_DIMS = PICK_WIDTH / PICK_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_TAKE,
    S_PUT,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t                  state;
  logic                    kind_q;
  logic [PICK_WIDTH-1:0]   picks_q;
  logic [CW-1:0]           count;
  logic [CW-1:0]           scan_k;
  logic                    v1;
  logic                    v2;
  logic                    v3;
  logic [POINT_WIDTH-1:0]  point_q;
  logic                    err_q;

  logic [CW-1:0]           live;
  logic [CW-1:0]           live_m1;
  logic [LW-1:0]           last_idx;
  logic                    full;
  logic                    reject;
  logic                    is_clear;
  logic                    scan_issue;
  logic [DIMENSIONS-1:0]   pick_bad;
  logic [PICK_BITS-1:0]    pick_raw [DIMENSIONS];
  logic [LW-1:0]           pick_idx [DIMENSIONS];
  logic [LW-1:0]           lane_coord [DIMENSIONS];
  logic [DIMENSIONS-1:0][SQW-1:0] lane_sq;
  logic [SW-1:0]           store_wdata;
  logic [SW-1:0]           store_rdata;
  logic [POINT_WIDTH-1:0]  point_pack;
  logic [MIN_W-1:0]        best_min;
  pool_op_t                pool_op;
  merge_op_t               merge_op;

  assign req_stall = (state != S_IDLE);

  assign live       = CW'(POINTS) - count;
  assign live_m1    = live - CW'(1);
  assign last_idx   = live_m1[LW-1:0];
  assign full       = (count == CW'(POINTS));
  assign reject     = full || (|pick_bad);
  assign is_clear   = (kind_q == KIND_CLEAR);
  assign scan_issue = (state == S_SCAN) && (scan_k < count);

  always_comb begin
    pool_op.clear   = (state == S_CHECK) && is_clear;
    pool_op.rd_pick = (state == S_CHECK) && !is_clear && !reject;
    pool_op.rd_last = (state == S_TAKE);
    pool_op.take    = (state == S_TAKE);
    pool_op.put     = (state == S_PUT);
    pool_op.sq_en   = v1;
    merge_op.clear  = (state == S_CHECK) && is_clear;
    merge_op.sum_en = v2;
    merge_op.cmp_en = v3;
  end

  // Dimensions whose pick slot lies above the request field read index zero.
  for (genvar gd = 0; gd < DIMENSIONS; gd++) begin : g_dim
    if (gd < FIELD_DIMS) begin : g_pick
      assign pick_raw[gd] = picks_q[gd*PICK_BITS +: PICK_BITS];
    end else begin : g_zero
      assign pick_raw[gd] = '0;
    end
    assign pick_bad[gd] = ((CW+PICK_BITS)'(pick_raw[gd]) >= (CW+PICK_BITS)'(live));
    assign pick_idx[gd] = LW'(pick_raw[gd]);
    assign store_wdata[gd*LW +: LW] = lane_coord[gd];

    lhbm_lane #(
      .POINTS (POINTS)
    ) u_lane (
      .clk      (clk),
      .rst      (rst),
      .op       (pool_op),
      .pick_idx (pick_idx[gd]),
      .last_idx (last_idx),
      .stored   (store_rdata[gd*LW +: LW]),
      .coord    (lane_coord[gd]),
      .sq       (lane_sq[gd])
    );
  end

  for (genvar gf = 0; gf < FIELD_DIMS; gf++) begin : g_field
    if (gf < DIMENSIONS) begin : g_used
      assign point_pack[gf*PICK_BITS +: PICK_BITS] = PICK_BITS'(lane_coord[gf]);
    end else begin : g_unused
      assign point_pack[gf*PICK_BITS +: PICK_BITS] = '0;
    end
  end

  lhbm_ram #(
    .WIDTH (SW),
    .DEPTH (POINTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (state == S_PUT),
    .wr_addr (count[LW-1:0]),
    .wr_data (store_wdata),
    .rd_en   (scan_issue),
    .rd_addr (scan_k[LW-1:0]),
    .rd_data (store_rdata)
  );

  lhbm_merge #(
    .DIMENSIONS (DIMENSIONS),
    .POINTS     (POINTS)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .op       (merge_op),
    .sq       (lane_sq),
    .best_min (best_min)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      scan_k    <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      v1 <= scan_issue;
      v2 <= v1;
      v3 <= v2;
      // In the result state a taken result is replaced by the new one below.
      if (rsp_valid && !rsp_stall && (state != S_RESULT)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            kind_q  <= req_data.kind;
            picks_q <= req_data.picks;
            state   <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (is_clear) begin
            count   <= '0;
            point_q <= '0;
            err_q   <= 1'b0;
            state   <= S_RESULT;
          end else if (reject) begin
            point_q <= '0;
            err_q   <= 1'b1;
            state   <= S_RESULT;
          end else begin
            state <= S_TAKE;
          end
        end
        S_TAKE: begin
          state <= S_PUT;
        end
        S_PUT: begin
          point_q <= point_pack;
          err_q   <= 1'b0;
          scan_k  <= '0;
          state   <= S_SCAN;
        end
        S_SCAN: begin
          // Wait for the last comparison to leave the merge stage.
          if (scan_issue) begin
            scan_k <= scan_k + CW'(1);
          end else if (!v1 && !v2 && !v3) begin
            count <= count + CW'(1);
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid             <= 1'b1;
            rsp_data.point        <= point_q;
            rsp_data.min_distance <= best_min;
            rsp_data.placed_count <= COUNT_OUT_W'(count);
            rsp_data.complete     <= (count == CW'(POINTS));
            rsp_data.error        <= err_q;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `LHBM_ASSERT_NEXT(a_min_never_rises, !merge_op.clear, best_min <= $past(best_min), "min rose")
  `LHBM_ASSERT_SAME(a_empty_keeps_start, count == '0, best_min == START_MIN, "empty min moved")
  `LHBM_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "not busy")

endmodule

FILE: test/latin_hypercube_builder_maximin_check.sv
`timescale 1ns / 1ps
// Checker for the Latin hypercube builder: watches both channels, predicts each result
// from its own copy of the level pools and placed points, and counts mismatches.
// Depends on lhbm_pkg.
module latin_hypercube_builder_maximin_check
  import lhbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      req_stall,
  input  lhbm_req_t req_data,
  input  logic      rsp_valid,
  input  logic      rsp_stall,
  input  lhbm_rsp_t rsp_data,
  output int        failures,
  output int        pending
);

  localparam int DIMS = DIMENSIONS_DEF;
  localparam int NPTS = POINTS_DEF;

  logic [PICK_BITS-1:0]   levels [DIMS][NPTS];
  logic [POINT_WIDTH-1:0] placed_points [NPTS];
  int                     placed;
  logic [MIN_W-1:0]       best_spread;
  lhbm_rsp_t              awaited [$];

  initial failures = 0;

  task automatic restart_levels();
    for (int d = 0; d < DIMS; d++) begin
      for (int j = 0; j < NPTS; j++) begin
        levels[d][j] = PICK_BITS'(j);
      end
    end
    placed = 0;
    best_spread = START_MIN;
  endtask

  task automatic predict_placement(input lhbm_req_t r, output lhbm_rsp_t res);
    int live;
    int idx;
    int spread;
    int diff;
    logic fits;
    logic [POINT_WIDTH-1:0] pt;
    res = '0;
    pt = '0;
    live = NPTS - placed;
    fits = (placed < NPTS);
    for (int d = 0; d < DIMS; d++) begin
      if (int'(r.picks[PICK_BITS*d +: PICK_BITS]) >= live) fits = 1'b0;
    end
    if (r.kind == KIND_CLEAR) begin
      restart_levels();
    end else if (!fits) begin
      res.error = 1'b1;
    end else begin
      // Take each level, then fill its slot from the last live pool entry.
      for (int d = 0; d < DIMS; d++) begin
        idx = int'(r.picks[PICK_BITS*d +: PICK_BITS]);
        pt[PICK_BITS*d +: PICK_BITS] = levels[d][idx];
        levels[d][idx] = levels[d][live-1];
        levels[d][live-1] = '0;
      end
      for (int k = 0; k < placed; k++) begin
        spread = 0;
        for (int d = 0; d < DIMS; d++) begin
          diff = int'(placed_points[k][PICK_BITS*d +: PICK_BITS])
               - int'(pt[PICK_BITS*d +: PICK_BITS]);
          spread += diff * diff;
        end
        if (spread < int'(best_spread)) best_spread = MIN_W'(spread);
      end
      placed_points[placed] = pt;
      placed++;
      res.point = pt;
    end
    res.min_distance = best_spread;
    res.placed_count = COUNT_OUT_W'(placed);
    res.complete     = (placed == NPTS);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : watch
    lhbm_rsp_t want;
    if (rst) begin
      restart_levels();
      awaited.delete();
      pending <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited.size() == 0) begin
          $error("result arrived with no request waiting for it");
          failures++;
        end else begin
          want = awaited.pop_front();
          check_field("point", want.point, rsp_data.point);
          check_field("min_distance", want.min_distance, rsp_data.min_distance);
          check_field("placed_count", want.placed_count, rsp_data.placed_count);
          check_field("complete", want.complete, rsp_data.complete);
          check_field("error", want.error, rsp_data.error);
        end
      end
      if (req_valid && !req_stall) begin
        predict_placement(req_data, want);
        awaited.push_back(want);
      end
      pending <= awaited.size();
    end
  end

endmodule

FILE: test/latin_hypercube_builder_maximin_test.sv
`timescale 1ns / 1ps
// Top of the Latin hypercube builder testbench: clock, reset, request stimulus and
// result stalls in several idling phases. Depends on lhbm_pkg, the builder and the checker module.
module latin_hypercube_builder_maximin_test;
  import lhbm_pkg::*;

  localparam int DIMS        = DIMENSIONS_DEF;
  localparam int NPTS        = POINTS_DEF;
  localparam int PHASE_ITEMS = 500;
  localparam int CYCLE_LIMIT = 1000000;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  lhbm_req_t req_data;
  logic      rsp_valid;
  logic      rsp_stall;
  lhbm_rsp_t rsp_data;

  int mismatches;
  int outstanding;
  int idle_pct;
  int stall_pct;
  int fill;
  int cycles = 0;
  int idle_by_phase [4]  = '{0, 81, 0, 24};
  int stall_by_phase [4] = '{0, 0, 81, 24};

  latin_hypercube_builder_maximin i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  latin_hypercube_builder_maximin_check i_check (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .failures  (mismatches),
    .pending   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** latin_hypercube_builder_maximin: FAILED **");
      $finish;
    end
  end

  task automatic send_request(input logic kind, input logic [PICK_WIDTH-1:0] picks);
    lhbm_req_t r;
    logic fits;
    r.kind = kind;
    r.picks = picks;
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    // Keep track of how full the block is so that random picks can stay in range.
    fits = (fill < NPTS);
    for (int d = 0; d < DIMS; d++) begin
      if (int'(picks[PICK_BITS*d +: PICK_BITS]) >= NPTS - fill) fits = 1'b0;
    end
    if (kind == KIND_CLEAR) fill = 0;
    else if (fits) fill++;
  endtask

  // The checker's pending count is registered, so look at it only from the next edge on.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int roll;
    logic [PICK_WIDTH-1:0] picks;
    rst = 1'b1;
    req_valid = 1'b0;
    req_data = '0;
    rsp_stall = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    fill = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: first point, out-of-range picks, highest legal index, a full
    // hypercube, a place request while full, and a clear with nonzero picks.
    send_request(KIND_CLEAR, 16'h0000);
    send_request(KIND_PLACE, 16'h0000);
    send_request(KIND_PLACE, 16'hFFFF);
    send_request(KIND_PLACE, 16'hEEEE);
    repeat (NPTS - 2) send_request(KIND_PLACE, 16'h0000);
    send_request(KIND_PLACE, 16'h0000);
    send_request(KIND_CLEAR, 16'hFFFF);
    send_request(KIND_PLACE, 16'hFFFF);
    send_request(KIND_PLACE, 16'h00F0);
    send_request(KIND_PLACE, 16'h1234);

    for (int phase = 0; phase < 4; phase++) begin
      drain();
      idle_pct = idle_by_phase[phase];
      stall_pct = stall_by_phase[phase];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 4 || (fill == NPTS && roll < 50)) begin
          send_request(KIND_CLEAR, PICK_WIDTH'($urandom_range(0, 65535)));
        end else if (roll < 10 || fill == NPTS) begin
          send_request(KIND_PLACE, PICK_WIDTH'($urandom_range(0, 65535)));
        end else begin
          for (int d = 0; d < DIMS; d++) begin
            picks[PICK_BITS*d +: PICK_BITS] = PICK_BITS'($urandom_range(0, NPTS - fill - 1));
          end
          send_request(KIND_PLACE, picks);
        end
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("** latin_hypercube_builder_maximin: PASSED **");
    end else begin
      $display("** latin_hypercube_builder_maximin: FAILED **");
    end
    $finish;
  end

endmodule

FILE: latin_hypercube_builder_maximin.f
+incdir+design
design/lhbm_pkg.sv
design/lhbm_ram.sv
design/lhbm_lane.sv
design/lhbm_merge.sv
design/latin_hypercube_builder_maximin.sv
test/latin_hypercube_builder_maximin_check.sv
test/latin_hypercube_builder_maximin_test.sv
